// ===== hw/rtl/x86e_pkg.sv =====
// Shared types and constants of the x86_64 instruction encoder.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package x86e_pkg;

    localparam int OFFSET_BITS = 24;
    localparam int MAX_BYTES   = 10;
    localparam int LEN_BITS    = $clog2(MAX_BYTES + 1);

    typedef enum logic [4:0] {
        OP_NOP     = 5'd0,
        OP_MOVI    = 5'd1,
        OP_MOV     = 5'd2,
        OP_LEA     = 5'd3,
        OP_ADD     = 5'd4,
        OP_SUB     = 5'd5,
        OP_AND     = 5'd6,
        OP_OR      = 5'd7,
        OP_XOR     = 5'd8,
        OP_IMUL    = 5'd9,
        OP_SHL     = 5'd10,
        OP_SHR     = 5'd11,
        OP_SAR     = 5'd12,
        OP_CMP     = 5'd13,
        OP_CMPI    = 5'd14,
        OP_JMP     = 5'd15,
        OP_JE      = 5'd16,
        OP_JNE     = 5'd17,
        OP_JL      = 5'd18,
        OP_JLE     = 5'd19,
        OP_JG      = 5'd20,
        OP_JGE     = 5'd21,
        OP_JZ      = 5'd22,
        OP_JNZ     = 5'd23,
        OP_CALL    = 5'd24,
        OP_RET     = 5'd25,
        OP_SYSCALL = 5'd26,
        OP_HALT    = 5'd27,
        OP_PUSH    = 5'd28,
        OP_POP     = 5'd29,
        OP_DATA    = 5'd30,
        OP_NOCODE  = 5'd31
    } op_t;

    typedef struct packed {
        logic [4:0]             operation;
        logic [3:0]             reg_a;
        logic [3:0]             reg_b;
        logic signed [63:0]     immediate;
        logic [OFFSET_BITS-1:0] here_offset;
        logic [OFFSET_BITS-1:0] target_offset;
    } in_item_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last_byte;
    } out_item_t;

    // decoded operation, first pipeline stage
    typedef struct packed {
        op_t                    op;
        logic [3:0]             reg_a;
        logic [3:0]             reg_b;
        logic [63:0]            imm;
        logic [OFFSET_BITS-1:0] here;
        logic [OFFSET_BITS-1:0] tgt;
        logic                   wide;
        logic [LEN_BITS-1:0]    len;
    } dec_t;

    // assembled bytes, byte 0 in the low bits
    typedef struct packed {
        logic [8*MAX_BYTES-1:0] bytes;
        logic [LEN_BITS-1:0]    len;
    } asm_t;

endpackage

// ===== hw/rtl/x86e_decode.sv =====
// Stage 1: classifies the operation, picks the encoding form and its length.
// Depends on x86e_pkg.
`timescale 1ns / 1ps

module x86e_decode (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  x86e_pkg::in_item_t s_payload,
    output logic              dec_valid,
    input  logic              dec_ready,
    output x86e_pkg::dec_t    dec_item
);
    import x86e_pkg::*;

    logic  valid_reg;
    dec_t  item_reg;
    dec_t  item_next;
    logic  fits32;
    logic  neg;
    logic  ax;

    assign s_ready   = !valid_reg || dec_ready;
    assign dec_valid = valid_reg;
    assign dec_item  = item_reg;

    assign fits32 = (&s_payload.immediate[63:31]) || !(|s_payload.immediate[63:31]);
    assign neg    = s_payload.immediate[63];
    assign ax     = s_payload.reg_a[3];

    always_comb begin
        item_next.op    = op_t'(s_payload.operation);
        item_next.reg_a = s_payload.reg_a;
        item_next.reg_b = s_payload.reg_b;
        item_next.imm   = s_payload.immediate;
        item_next.here  = s_payload.here_offset;
        item_next.tgt   = s_payload.target_offset;
        item_next.wide  = 1'b0;
        item_next.len   = LEN_BITS'(0);
        unique case (item_next.op)
            OP_NOP, OP_RET, OP_HALT, OP_DATA: item_next.len = LEN_BITS'(1);
            OP_MOVI: begin
                item_next.wide = !fits32;
                item_next.len  = fits32 ? LEN_BITS'(7) : LEN_BITS'(10);
            end
            OP_LEA: begin
                item_next.wide = neg;
                item_next.len  = neg ? LEN_BITS'(10) : LEN_BITS'(7);
            end
            OP_MOV, OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR,
            OP_SHL, OP_SHR, OP_SAR, OP_CMP: item_next.len = LEN_BITS'(3);
            OP_IMUL: item_next.len = LEN_BITS'(4);
            OP_CMPI: item_next.len = LEN_BITS'(7);
            OP_JMP, OP_CALL: item_next.len = LEN_BITS'(5);
            OP_JE, OP_JNE, OP_JL, OP_JLE, OP_JG, OP_JGE, OP_JZ, OP_JNZ:
                item_next.len = LEN_BITS'(6);
            OP_SYSCALL: item_next.len = LEN_BITS'(2);
            OP_PUSH, OP_POP: item_next.len = ax ? LEN_BITS'(2) : LEN_BITS'(1);
            OP_NOCODE: item_next.len = LEN_BITS'(0);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== hw/rtl/x86e_assemble.sv =====
// Stage 2: computes rel32/disp32 and lays out the instruction bytes.
// Depends on x86e_pkg.
`timescale 1ns / 1ps

module x86e_assemble (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           dec_valid,
    output logic           dec_ready,
    input  x86e_pkg::dec_t dec_item,
    output logic           asm_valid,
    input  logic           asm_ready,
    output x86e_pkg::asm_t asm_item
);
    import x86e_pkg::*;

    logic        valid_reg;
    asm_t        item_reg;
    asm_t        item_next;
    logic [7:0]  b [MAX_BYTES];
    logic [31:0] rel32;
    logic [31:0] end_ofs;
    logic [2:0]  a7;
    logic [2:0]  b7;
    logic        ax;
    logic        bx;
    logic [31:0] imm32;

    function automatic logic [7:0] rex_w(input logic r, input logic x);
        return {4'h4, 1'b1, r, 1'b0, x};
    endfunction

    function automatic logic [7:0] modrm(input logic [1:0] md, input logic [2:0] rg,
                                         input logic [2:0] rm);
        return {md, rg, rm};
    endfunction

    assign dec_ready = !valid_reg || asm_ready;
    assign asm_valid = valid_reg;
    assign asm_item  = item_reg;

    assign a7    = dec_item.reg_a[2:0];
    assign b7    = dec_item.reg_b[2:0];
    assign ax    = dec_item.reg_a[3];
    assign bx    = dec_item.reg_b[3];
    assign imm32 = dec_item.imm[31:0];

    // displacement is taken from the end of the instruction
    assign end_ofs = 32'(dec_item.here) + 32'(dec_item.len);
    assign rel32   = 32'(dec_item.tgt) - end_ofs;

    always_comb begin
        for (int i = 0; i < MAX_BYTES; i++) begin
            b[i] = 8'h00;
        end
        unique case (dec_item.op)
            OP_NOP: b[0] = 8'h90;
            OP_MOVI, OP_LEA: begin
                if (dec_item.wide) begin
                    b[0] = rex_w(1'b0, ax);
                    b[1] = {5'b10111, a7};
                    for (int i = 0; i < 8; i++) begin
                        b[2+i] = dec_item.imm[8*i +: 8];
                    end
                end else if (dec_item.op == OP_MOVI) begin
                    b[0] = rex_w(1'b0, ax);
                    b[1] = 8'hC7;
                    b[2] = modrm(2'b11, 3'd0, a7);
                    for (int i = 0; i < 4; i++) begin
                        b[3+i] = imm32[8*i +: 8];
                    end
                end else begin
                    b[0] = rex_w(ax, 1'b0);
                    b[1] = 8'h8D;
                    b[2] = modrm(2'b00, a7, 3'd5);
                    for (int i = 0; i < 4; i++) begin
                        b[3+i] = rel32[8*i +: 8];
                    end
                end
            end
            OP_MOV, OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_CMP: begin
                b[0] = rex_w(bx, ax);
                unique case (dec_item.op)
                    OP_MOV:  b[1] = 8'h89;
                    OP_ADD:  b[1] = 8'h01;
                    OP_SUB:  b[1] = 8'h29;
                    OP_AND:  b[1] = 8'h21;
                    OP_OR:   b[1] = 8'h09;
                    OP_XOR:  b[1] = 8'h31;
                    default: b[1] = 8'h39;
                endcase
                b[2] = modrm(2'b11, b7, a7);
            end
            OP_IMUL: begin
                b[0] = rex_w(ax, bx);
                b[1] = 8'h0F;
                b[2] = 8'hAF;
                b[3] = modrm(2'b11, a7, b7);
            end
            OP_SHL, OP_SHR, OP_SAR: begin
                b[0] = rex_w(1'b0, ax);
                b[1] = 8'hD3;
                unique case (dec_item.op)
                    OP_SHL:  b[2] = modrm(2'b11, 3'd4, a7);
                    OP_SHR:  b[2] = modrm(2'b11, 3'd5, a7);
                    default: b[2] = modrm(2'b11, 3'd7, a7);
                endcase
            end
            OP_CMPI: begin
                b[0] = rex_w(1'b0, ax);
                b[1] = 8'h81;
                b[2] = modrm(2'b11, 3'd7, a7);
                for (int i = 0; i < 4; i++) begin
                    b[3+i] = imm32[8*i +: 8];
                end
            end
            OP_JMP, OP_CALL: begin
                b[0] = (dec_item.op == OP_JMP) ? 8'hE9 : 8'hE8;
                for (int i = 0; i < 4; i++) begin
                    b[1+i] = rel32[8*i +: 8];
                end
            end
            OP_JE, OP_JNE, OP_JL, OP_JLE, OP_JG, OP_JGE, OP_JZ, OP_JNZ: begin
                b[0] = 8'h0F;
                unique case (dec_item.op)
                    OP_JE, OP_JZ:   b[1] = 8'h84;
                    OP_JNE, OP_JNZ: b[1] = 8'h85;
                    OP_JL:          b[1] = 8'h8C;
                    OP_JLE:         b[1] = 8'h8E;
                    OP_JG:          b[1] = 8'h8F;
                    default:        b[1] = 8'h8D;
                endcase
                for (int i = 0; i < 4; i++) begin
                    b[2+i] = rel32[8*i +: 8];
                end
            end
            OP_RET:     b[0] = 8'hC3;
            OP_SYSCALL: begin
                b[0] = 8'h0F;
                b[1] = 8'h05;
            end
            OP_HALT: b[0] = 8'hF4;
            OP_PUSH, OP_POP: begin
                if (ax) begin
                    b[0] = 8'h41;
                    b[1] = (dec_item.op == OP_PUSH) ? {5'b01010, a7} : {5'b01011, a7};
                end else begin
                    b[0] = (dec_item.op == OP_PUSH) ? {5'b01010, a7} : {5'b01011, a7};
                end
            end
            OP_DATA:   b[0] = dec_item.imm[7:0];
            OP_NOCODE: b[0] = 8'h00;
        endcase
        for (int i = 0; i < MAX_BYTES; i++) begin
            item_next.bytes[8*i +: 8] = b[i];
        end
        item_next.len = dec_item.len;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (dec_ready) begin
            valid_reg <= dec_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (dec_ready && dec_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== hw/rtl/x86e_serialize.sv =====
// Stage 3: shift register that sends one byte per beat and flags the last one.
// Depends on x86e_pkg.
`timescale 1ns / 1ps

module x86e_serialize (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                asm_valid,
    output logic                asm_ready,
    input  x86e_pkg::asm_t      asm_item,
    output logic                m_valid,
    input  logic                m_ready,
    output x86e_pkg::out_item_t m_payload
);
    import x86e_pkg::*;

    logic [8*MAX_BYTES-1:0] buf_reg;
    logic [LEN_BITS-1:0]    cnt_reg;
    logic                   room;
    logic                   load;
    logic                   shift;

    assign m_valid             = (cnt_reg != LEN_BITS'(0));
    assign m_payload.code_byte = buf_reg[7:0];
    assign m_payload.last_byte = (cnt_reg == LEN_BITS'(1));

    assign room      = !m_valid || (m_payload.last_byte && m_ready);
    // empty instructions drop out here without a beat
    assign asm_ready = room || (asm_item.len == LEN_BITS'(0));
    assign load      = asm_valid && room && (asm_item.len != LEN_BITS'(0));
    assign shift     = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= LEN_BITS'(0);
        end else if (load) begin
            cnt_reg <= asm_item.len;
        end else if (shift) begin
            cnt_reg <= cnt_reg - LEN_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            buf_reg <= asm_item.bytes;
        end else if (shift) begin
            buf_reg <= buf_reg >> 8;
        end
    end

endmodule

// ===== hw/rtl/x86_64_instruction_encoder.sv =====
// Encodes simple RISC-like operations into x86_64 machine code bytes.
// Instantiates x86e_decode, x86e_assemble and x86e_serialize; uses x86e_pkg.
//
// Input channel s_: one operation per beat (opcode, registers, immediate,
// own offset, resolved target offset). Result channel m_: one code byte per
// beat, last_byte high on the final byte of each instruction.
// The first byte is valid on m_payload once the operation has passed the
// decode and assemble registers and the byte shifter has loaded it. An
// instruction of N bytes (1 to 10) occupies the byte shifter until its last
// byte is taken, and the next instruction loads as that byte goes; while the
// shifter is busy, s_ready drops once the decode and assemble stages fill.
// Label and no-code operations yield no bytes and drop out without a beat.
// Reset (aresetn low, synchronous) empties all three stages; nothing in
// flight is kept. When the receiver holds m_ready low the current byte stays
// on m_payload, the stages behind fill and s_ready drops; nothing is lost
// or repeated.
`timescale 1ns / 1ps

module x86_64_instruction_encoder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  x86e_pkg::in_item_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output x86e_pkg::out_item_t m_payload
);
    import x86e_pkg::*;

    logic dec_valid;
    logic dec_ready;
    dec_t dec_item;
    logic asm_valid;
    logic asm_ready;
    asm_t asm_item;

    x86e_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .dec_valid (dec_valid),
        .dec_ready (dec_ready),
        .dec_item  (dec_item)
    );

    x86e_assemble u_assemble (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .dec_valid (dec_valid),
        .dec_ready (dec_ready),
        .dec_item  (dec_item),
        .asm_valid (asm_valid),
        .asm_ready (asm_ready),
        .asm_item  (asm_item)
    );

    x86e_serialize u_serialize (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .asm_valid (asm_valid),
        .asm_ready (asm_ready),
        .asm_item  (asm_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

// ===== hw/rtl/x86e_checker.sv =====
// Port-level checks on the encoder's result channel, bound to the top level.
// Depends on x86e_pkg and x86_64_instruction_encoder.
`timescale 1ns / 1ps

module x86e_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input x86e_pkg::out_item_t m_payload
);
    import x86e_pkg::*;

    // a stalled beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result beat changed while stalled");

    // the channel is empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // bytes of one instruction follow without a gap
    a_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_payload.last_byte |=> m_valid)
        else $error("gap inside an instruction");

endmodule

bind x86_64_instruction_encoder x86e_checker u_x86e_checker (.*);
